FILE: design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared payload types for the prime sum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic                     is_prime;
    logic signed [DATA_W-1:0] prime_sum;
    logic                     sum_final;
  } out_t;

endpackage

`default_nettype wire

FILE: design/prime_sum_accumulator.sv
// ----------------------------------------------------------------------------
// prime_sum_accumulator
// Trial-division primality test with a running sum of the primes found.
// ----------------------------------------------------------------------------
// One item is in work at a time and in_stall stays high until its result
// moves to the output register. A value below 2 goes straight to the done
// state. Otherwise each trial divisor takes a step that compares the
// divisor square with the value, then a pass through the bit-serial
// restoring remainder unit, which sets the rate. A prime is tried with every
// divisor d from 2 while d*d <= n; a composite stops at its smallest factor.
// The next item is taken while a finished result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sum_accumulator #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire psa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output psa_pkg::out_t     out_data
);

  import psa_pkg::*;

  localparam int unsigned NW = VALUE_WIDTH - 1;
  localparam int unsigned DW = VALUE_WIDTH / 2 + 1;
  localparam int unsigned CW = $clog2(NW);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [NW-1:0]          n_r, n_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [VALUE_WIDTH-1:0] sq_r, sq_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   prime_r, prime_nxt;
  logic                   last_r, last_nxt;
  logic [VALUE_WIDTH-1:0] sum_r, sum_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic [VALUE_WIDTH-1:0] in_v;
  logic                   cand;
  logic [DW:0]            trial;
  logic                   trial_ge;
  logic [DW-1:0]          rem_step;
  logic [VALUE_WIDTH-1:0] sum_new;
  logic                   load;

  assign in_v     = in_data.value[VALUE_WIDTH-1:0];
  assign cand     = !in_v[VALUE_WIDTH-1] && (in_v >= VALUE_WIDTH'(2));
  assign trial    = {rem_r, n_r[cnt_r]};
  assign trial_ge = trial >= {1'b0, d_r};
  assign rem_step = trial_ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
  assign sum_new  = prime_r ? sum_r + {1'b0, n_r} : sum_r;
  assign load     = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    prime_nxt     = prime_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_v[NW-1:0];
          last_nxt  = in_data.last;
          d_nxt     = DW'(2);
          sq_nxt    = VALUE_WIDTH'(4);
          prime_nxt = 1'b0;
          state_nxt = cand ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = CW'(NW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (rem_step == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + VALUE_WIDTH'({d_r, 1'b1});
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.is_prime  = prime_r;
          out_data_nxt.prime_sum = DATA_W'($signed(sum_new));
          out_data_nxt.sum_final = last_r;
          sum_nxt                = last_r ? '0 : sum_new;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    prime_r    <= prime_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  a_square_tracks_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> sq_r == VALUE_WIDTH'(d_r) * VALUE_WIDTH'(d_r))
    else $error("divisor square out of step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < d_r)
    else $error("partial remainder not below divisor");

  a_divisor_from_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_DIV) |-> d_r >= DW'(2))
    else $error("divisor below two");

  a_sum_clears_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && last_r |=> sum_r == '0)
    else $error("sum not cleared after final transfer");

  a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && state_r == S_IDLE)
    else $error("result lost on load");

endmodule

`default_nettype wire
